// ===== design/ubsd_pkg.sv =====
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; imported by every module of the block.
package ubsd_pkg;

    // Queue geometry between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Fixed byte ranges and values
    localparam logic [7:0]  LEAD_TWO_MIN   = 8'hC0;
    localparam logic [7:0]  LEAD_THREE_MIN = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR_MIN  = 8'hF0;
    localparam logic [7:0]  LEAD_BAD_MIN   = 8'hF8;
    localparam logic [31:0] REPLACEMENT    = 32'h0000_FFFD;
    localparam logic [31:0] OFFSET_ONE     = 32'h0000_3080;
    localparam logic [31:0] OFFSET_TWO     = 32'h000E_2080;
    localparam logic [31:0] OFFSET_THREE   = 32'h03C8_2080;

    // What the back end does with one queued byte
    typedef enum logic [1:0] {
        KIND_LITERAL,
        KIND_REPLACE,
        KIND_LEAD,
        KIND_TRAIL
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [1:0] trailers;   // lead only: trailers that follow
        logic       last;       // trail only: closes the sequence
        logic [7:0] data;       // raw byte
    } op_t;

    // Queue status seen by front, back and checks
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Offset removed from the accumulated value, by sequence length
    function automatic logic [31:0] length_offset(input logic [1:0] trailers);
        logic [31:0] off;
        unique case (trailers)
            2'd1:    off = OFFSET_ONE;
            2'd2:    off = OFFSET_TWO;
            2'd3:    off = OFFSET_THREE;
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

// ===== design/ubsd_front.sv =====
// Front end: accepts input words, classifies each byte and pushes an op.
// Depends on ubsd_pkg.
module ubsd_front import ubsd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_data,
    input  queue_status_t q_status,
    output logic          push,
    output op_t           push_op
);

    logic [1:0] pend_reg, pend_next;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Classify against the trailer count still expected
    always_comb begin
        pend_next        = pend_reg;
        push_op.data     = in_data;
        push_op.trailers = '0;
        push_op.last     = 1'b0;
        push_op.kind     = KIND_LITERAL;
        if (pend_reg != 2'd0) begin
            push_op.kind = KIND_TRAIL;
            push_op.last = (pend_reg == 2'd1);
            pend_next    = pend_reg - 2'd1;
        end else if (in_data < LEAD_TWO_MIN) begin
            push_op.kind = KIND_LITERAL;
        end else if (in_data >= LEAD_BAD_MIN) begin
            push_op.kind = KIND_REPLACE;
        end else begin
            push_op.kind = KIND_LEAD;
            if (in_data < LEAD_THREE_MIN) begin
                push_op.trailers = 2'd1;
            end else if (in_data < LEAD_FOUR_MIN) begin
                push_op.trailers = 2'd2;
            end else begin
                push_op.trailers = 2'd3;
            end
            pend_next = push_op.trailers;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (push) begin
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== design/ubsd_queue.sv =====
// Short op queue between front and back ends.
// Depends on ubsd_pkg.
module ubsd_queue import ubsd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output op_t           head_op,
    output queue_status_t status
);

    op_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0] wr_ptr_reg, rd_ptr_reg;

    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.full  = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]) &&
                          (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign head_op      = mem[rd_ptr_reg[QUEUE_AW-1:0]];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg[QUEUE_AW-1:0]] <= push_op;
        end
    end

    // Pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

// ===== design/ubsd_back.sv =====
// Back end: runs queued ops through the accumulator, drives the output word.
// Depends on ubsd_pkg.
module ubsd_back import ubsd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  op_t           head_op,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_data
);

    logic [31:0] acc_reg, acc_next;
    logic [1:0]  trailers_reg, trailers_next;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        emit;
    logic [31:0] emit_val;
    logic [31:0] shifted_sum;

    assign pop       = !q_status.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign shifted_sum = {acc_reg[25:0], 6'b0} + {24'b0, head_op.data};

    // Per-op update and result
    always_comb begin
        acc_next      = acc_reg;
        trailers_next = trailers_reg;
        emit          = 1'b0;
        emit_val      = {24'b0, head_op.data};
        unique case (head_op.kind)
            KIND_LITERAL: begin
                emit = 1'b1;
            end
            KIND_REPLACE: begin
                emit     = 1'b1;
                emit_val = REPLACEMENT;
            end
            KIND_LEAD: begin
                acc_next      = {24'b0, head_op.data};
                trailers_next = head_op.trailers;
            end
            KIND_TRAIL: begin
                acc_next = shifted_sum;
                emit     = head_op.last;
                emit_val = shifted_sum - length_offset(trailers_reg);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            trailers_reg <= '0;
        end else if (pop) begin
            acc_reg      <= acc_next;
            trailers_reg <= trailers_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= emit;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_data_reg <= emit_val;
        end
    end

endmodule

// ===== design/utf8_byte_stream_decoder_top.sv =====
// UTF-8 byte stream decoder: one byte per input word, one 32-bit code point
// per completed sequence. Takes a byte every cycle while the queue is not
// full; a code point is registered into the queue, then into the output
// register, before it is valid on m_tdata.
// The four-entry queue between classifier and accumulator keeps input flowing
// while the output is stalled. Trailer bytes are not checked; no flush.
// Depends on ubsd_pkg, ubsd_front, ubsd_queue, ubsd_back.
module utf8_byte_stream_decoder_top import ubsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] code_point
);

    logic          push, pop;
    op_t           push_op, head_op;
    queue_status_t q_status;

    ubsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .push_op  (push_op)
    );

    ubsd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    ubsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_op   (head_op),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // Checks
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_lead_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_op.kind == KIND_LEAD) |-> (push_op.trailers != 2'd0))
        else $error("lead op without trailers");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.full && !pop) |=> q_status.full)
        else $error("full queue drained without pop");

endmodule
